>>> hdl/svtt_pkg.sv
package svtt_pkg;

  // Widths of the datapath
  localparam int unsigned SAMPLE_BITS     = 10;
  localparam int unsigned STEP_COUNT_BITS = 12;
  localparam int unsigned MODE_W          = 3;
  localparam int unsigned SPM_W           = 12;
  localparam int unsigned CNT_W           = 5;
  localparam int unsigned THR_W           = 20;
  localparam int unsigned SCALE_W         = 10;
  localparam int unsigned TEMP_W          = 20;
  localparam int unsigned COIL_W          = 4;
  localparam int unsigned EVENT_W         = 4;
  localparam int unsigned PROD_W          = SAMPLE_BITS + SCALE_W;
  localparam int unsigned SUM_W           = PROD_W + CNT_W;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 20;
  localparam int unsigned S_TDATA_W       = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W       = ((COIL_W + 1 + TEMP_W + 7) / 8) * 8;

  // Configuration reset values
  localparam logic [SPM_W-1:0]   SPM_RST   = SPM_W'(2048);
  localparam logic [CNT_W-1:0]   BASE_RST  = CNT_W'(20);
  localparam logic [CNT_W-1:0]   WIN_RST   = CNT_W'(10);
  localparam logic [THR_W-1:0]   THR_RST   = THR_W'(5120);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(700);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEPS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_THRESH   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = CFG_IDX_W'(4);

  // Input item kinds
  localparam logic [MODE_W-1:0] MODE_OPEN   = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_CLOSE  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_TICK   = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_SAMPLE = MODE_W'(4);

  // Result events
  localparam logic [EVENT_W-1:0] EV_NONE     = EVENT_W'(0);
  localparam logic [EVENT_W-1:0] EV_OPENING  = EVENT_W'(1);
  localparam logic [EVENT_W-1:0] EV_OPENED   = EVENT_W'(2);
  localparam logic [EVENT_W-1:0] EV_CLOSING  = EVENT_W'(3);
  localparam logic [EVENT_W-1:0] EV_CLOSED   = EVENT_W'(4);
  localparam logic [EVENT_W-1:0] EV_INVALID  = EVENT_W'(5);
  localparam logic [EVENT_W-1:0] EV_BASELINE = EVENT_W'(6);
  localparam logic [EVENT_W-1:0] EV_WINDOW   = EVENT_W'(7);
  localparam logic [EVENT_W-1:0] EV_TRIP     = EVENT_W'(8);

  typedef enum logic [1:0] {
    VS_CLOSED  = 2'd0,
    VS_OPENING = 2'd1,
    VS_OPEN    = 2'd2,
    VS_CLOSING = 2'd3
  } valve_e;

  // Forward full-step coil pattern
  function automatic logic [COIL_W-1:0] fwd_coils(input logic [1:0] ph);
    logic [COIL_W-1:0] c;
    case (ph)
      2'd0:    c = 4'h3;
      2'd1:    c = 4'h6;
      2'd2:    c = 4'hC;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

  // Reverse full-step coil pattern
  function automatic logic [COIL_W-1:0] rev_coils(input logic [1:0] ph);
    logic [COIL_W-1:0] c;
    case (ph)
      2'd0:    c = 4'h3;
      2'd1:    c = 4'h9;
      2'd2:    c = 4'hC;
      default: c = 4'h6;
    endcase
    return c;
  endfunction

  // Clamp the move length to what the step counter can hold
  function automatic logic [STEP_COUNT_BITS-1:0] step_limit(input logic [SPM_W-1:0] spm);
    logic [SPM_W+STEP_COUNT_BITS-1:0] wide;
    logic [SPM_W+STEP_COUNT_BITS-1:0] cmax;
    logic [STEP_COUNT_BITS-1:0]       lim;
    wide = {{STEP_COUNT_BITS{1'b0}}, spm};
    cmax = {{SPM_W{1'b0}}, {STEP_COUNT_BITS{1'b1}}};
    if (wide > cmax) lim = {STEP_COUNT_BITS{1'b1}};
    else             lim = wide[STEP_COUNT_BITS-1:0];
    return lim;
  endfunction

endpackage

>>> hdl/svtt_div.sv
// Restoring divider: one quotient bit per cycle, one for each of the SUM_W dividend bits
module svtt_div
  import svtt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [SUM_W-1:0] quot_o
);

  localparam int unsigned ITER_W = $clog2(SUM_W);

  logic              busy_q;
  logic [ITER_W-1:0] iter_q;
  logic [SUM_W-1:0]  quot_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  div_q;
  logic              done_q;

  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    trial;
  logic              fits;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    shifted = {rem_q, quot_q[SUM_W-1]};
    trial   = shifted - {1'b0, div_q};
    fits    = (shifted >= {1'b0, div_q});
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= ITER_W'(SUM_W - 1);
      end else if (busy_q) begin
        iter_q <= iter_q - ITER_W'(1);
        if (iter_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[SUM_W-2:0], fits};
      rem_q  <= fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> hdl/stepper_valve_thermal_trip_top.sv
// Stepper valve controller with thermal trip.
// Input items arrive on the s_axis channel: tuser carries the item kind
// (open, close, invalid command, step tick, temperature sample), tdata the
// ADC sample. Every input item gives exactly one result item on m_axis:
// tdata carries coil drive, valve-open flag and reported temperature, tuser
// the event code. Configuration is a plain write port (cfg_we_i, cfg_idx_i,
// cfg_data_i) that must only be used while the block is idle.
// Sequence: a command or tick passes the execute and finish states before its
// result is offered, and a sample that does not close an average also the
// accumulate state. A sample that completes the baseline passes multiply,
// accumulate and a bit-serial divide, and one that completes a window also
// the distance check. The next item is taken in the cycle after the result
// is loaded.
// s_axis_tready is high only while the sequencer is idle. If the receiver
// stalls with a result still held, the next finished result waits in the
// sequencer and no further item is accepted.
// Reset returns the valve to closed, coils off, averages cleared and all
// configuration registers to their defaults; no result is pending.
module stepper_valve_thermal_trip_top
  import svtt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [9:0] sample, rest zero
  input  logic [MODE_W-1:0]     s_axis_tuser,  // [2:0] mode
  // Result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,  // [3:0] coils, [4] valve_open,
                                               // [24:5] temperature, rest zero
  output logic [EVENT_W-1:0]    m_axis_tuser   // [3:0] event_res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ACC,
    ST_DIV,
    ST_DIST,
    ST_FIN
  } seq_e;

  // Configuration registers
  logic [SPM_W-1:0]   spm_q;
  logic [CNT_W-1:0]   base_n_q;
  logic [CNT_W-1:0]   win_n_q;
  logic [THR_W-1:0]   thr_q;
  logic [SCALE_W-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spm_q    <= SPM_RST;
      base_n_q <= BASE_RST;
      win_n_q  <= WIN_RST;
      thr_q    <= THR_RST;
      scale_q  <= SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STEPS:  spm_q    <= cfg_data_i[SPM_W-1:0];
        REG_BASE:   base_n_q <= cfg_data_i[CNT_W-1:0];
        REG_WINDOW: win_n_q  <= cfg_data_i[CNT_W-1:0];
        REG_THRESH: thr_q    <= cfg_data_i[THR_W-1:0];
        REG_SCALE:  scale_q  <= cfg_data_i[SCALE_W-1:0];
        default:    ;
      endcase
    end
  end

  // Sequencer and valve state
  seq_e                       st_q;
  valve_e                     valve_q;
  logic [1:0]                 phase_q;
  logic [STEP_COUNT_BITS-1:0] steps_q;
  logic                       base_done_q;
  logic [CNT_W-1:0]           taken_q;
  logic [SUM_W-1:0]           sum_q;
  logic [TEMP_W-1:0]          baseline_q;
  logic [COIL_W-1:0]          coil_q;

  // Item being worked
  logic [MODE_W-1:0]          mode_q;
  logic [SAMPLE_BITS-1:0]     sample_q;
  logic [PROD_W-1:0]          prod_q;
  logic [TEMP_W-1:0]          avg_q;
  logic [EVENT_W-1:0]         ev_q;
  logic [TEMP_W-1:0]          temp_q;

  // Result register
  logic                       out_vld_q;
  logic [COIL_W-1:0]          out_coil_q;
  logic                       out_open_q;
  logic [EVENT_W-1:0]         out_ev_q;
  logic [TEMP_W-1:0]          out_temp_q;

  // Divider
  logic                       div_start;
  logic [SUM_W-1:0]           div_dividend;
  logic [CNT_W-1:0]           div_divisor;
  logic                       div_done;
  logic [SUM_W-1:0]           div_quot;

  // Combinational helpers
  logic [SUM_W-1:0]           sum_add;
  logic [CNT_W-1:0]           taken_inc;
  logic [CNT_W-1:0]           avg_n;
  logic [TEMP_W-1:0]          quot_sat;
  logic [TEMP_W-1:0]          deviation;
  logic                       out_free;

  assign s_axis_tready = (st_q == ST_IDLE);
  assign out_free      = !out_vld_q || m_axis_tready;

  always_comb begin
    sum_add   = sum_q + {{CNT_W{1'b0}}, prod_q};
    taken_inc = taken_q + CNT_W'(1);
    if (base_done_q) avg_n = (win_n_q == '0) ? CNT_W'(1) : win_n_q;
    else             avg_n = (base_n_q == '0) ? CNT_W'(1) : base_n_q;
    // Saturate the quotient to the temperature width
    if (div_quot[SUM_W-1:TEMP_W] != '0) quot_sat = {TEMP_W{1'b1}};
    else                                 quot_sat = div_quot[TEMP_W-1:0];
    deviation = (avg_q > baseline_q) ? (avg_q - baseline_q) : (baseline_q - avg_q);
  end

  assign div_start    = (st_q == ST_ACC) && (taken_inc >= avg_n);
  assign div_dividend = sum_add;
  assign div_divisor  = avg_n;

  svtt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Sequencer, valve state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      valve_q     <= VS_CLOSED;
      phase_q     <= '0;
      steps_q     <= '0;
      base_done_q <= 1'b0;
      taken_q     <= '0;
      sum_q       <= '0;
      baseline_q  <= '0;
      coil_q      <= '0;
      out_vld_q   <= 1'b0;
      out_coil_q  <= '0;
      out_open_q  <= 1'b0;
      out_ev_q    <= '0;
      out_temp_q  <= '0;
    end else begin
      // Raise the result flag when a result is loaded, drop it once taken
      if (st_q == ST_FIN && out_free) out_vld_q <= 1'b1;
      else if (m_axis_tready)          out_vld_q <= 1'b0;

      case (st_q)
        ST_IDLE: begin
          if (s_axis_tvalid) st_q <= ST_EXEC;
        end

        ST_EXEC: begin
          st_q <= ST_FIN;
          case (mode_q)
            MODE_OPEN: begin
              if (valve_q == VS_CLOSED) begin
                valve_q <= VS_OPENING;
                steps_q <= '0;
                taken_q <= '0;
                sum_q   <= '0;
              end
            end
            MODE_CLOSE: begin
              if (valve_q == VS_OPEN) begin
                valve_q     <= VS_CLOSING;
                steps_q     <= '0;
                taken_q     <= '0;
                sum_q       <= '0;
                base_done_q <= 1'b0;
              end
            end
            MODE_TICK: begin
              if (valve_q == VS_OPENING || valve_q == VS_CLOSING) begin
                if (steps_q >= step_limit(spm_q)) begin
                  coil_q  <= '0;
                  valve_q <= (valve_q == VS_OPENING) ? VS_OPEN : VS_CLOSED;
                end else begin
                  coil_q  <= (valve_q == VS_OPENING) ? fwd_coils(phase_q)
                                                     : rev_coils(phase_q);
                  phase_q <= phase_q + 2'd1;
                  steps_q <= steps_q + STEP_COUNT_BITS'(1);
                end
              end
            end
            MODE_SAMPLE: begin
              if (valve_q == VS_OPEN) st_q <= ST_ACC;
            end
            default: ;
          endcase
        end

        ST_ACC: begin
          if (div_start) begin
            taken_q <= '0;
            sum_q   <= '0;
            st_q    <= ST_DIV;
          end else begin
            taken_q <= taken_inc;
            sum_q   <= sum_add;
            st_q    <= ST_FIN;
          end
        end

        ST_DIV: begin
          if (div_done) begin
            if (!base_done_q) begin
              baseline_q  <= quot_sat;
              base_done_q <= 1'b1;
              st_q        <= ST_FIN;
            end else begin
              st_q <= ST_DIST;
            end
          end
        end

        ST_DIST: begin
          if (deviation > thr_q) begin
            valve_q     <= VS_CLOSING;
            steps_q     <= '0;
            base_done_q <= 1'b0;
          end
          st_q <= ST_FIN;
        end

        ST_FIN: begin
          if (out_free) begin
            out_coil_q <= coil_q;
            out_open_q <= (valve_q == VS_OPENING || valve_q == VS_OPEN);
            out_ev_q   <= ev_q;
            out_temp_q <= temp_q;
            st_q       <= ST_IDLE;
          end
        end

        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // Item payload, event and temperature for the result
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && s_axis_tvalid) begin
      mode_q   <= s_axis_tuser;
      sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end

    case (st_q)
      ST_EXEC: begin
        prod_q <= sample_q * scale_q;
        temp_q <= '0;
        case (mode_q)
          MODE_OPEN:   ev_q <= (valve_q == VS_CLOSED) ? EV_OPENING : EV_INVALID;
          MODE_CLOSE:  ev_q <= (valve_q == VS_OPEN) ? EV_CLOSING : EV_INVALID;
          MODE_TICK: begin
            if ((valve_q == VS_OPENING || valve_q == VS_CLOSING) &&
                steps_q >= step_limit(spm_q))
              ev_q <= (valve_q == VS_OPENING) ? EV_OPENED : EV_CLOSED;
            else
              ev_q <= EV_NONE;
          end
          MODE_SAMPLE: ev_q <= EV_NONE;
          default:     ev_q <= EV_INVALID;
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          avg_q  <= quot_sat;
          temp_q <= quot_sat;
          ev_q   <= EV_BASELINE;
        end
      end
      ST_DIST: begin
        ev_q <= (deviation > thr_q) ? EV_TRIP : EV_WINDOW;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_ev_q;
  assign m_axis_tdata  = {{(M_TDATA_W - COIL_W - 1 - TEMP_W){1'b0}},
                          out_temp_q, out_open_q, out_coil_q};

endmodule
